// ===== rtl/serial_two_kind_frame_parser_defines.svh =====
// Assertion helpers for the parser RTL (stkfp_parser).
`ifndef SERIAL_TWO_KIND_FRAME_PARSER_DEFINES_SVH
`define SERIAL_TWO_KIND_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define STKFP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stkfp: same-cycle check failed");

// Next-cycle implication, masked while reset is high.
`define STKFP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stkfp: next-cycle check failed");

`endif

// ===== rtl/stkfp_pkg.sv =====
`timescale 1ns / 1ps
package stkfp_pkg;

   localparam int BufDepth  = 64;
   localparam int AddrW     = $clog2(BufDepth);
   localparam int CountW    = AddrW + 1;
   localparam int NeedW     = 9;
   localparam int FailLimit = 7;
   localparam int ErrRunW   = 4;
   localparam int FifoDepth = 4;
   localparam int FifoAddrW = $clog2(FifoDepth);

   localparam logic [7:0] SyncByte       = 8'hFF;
   localparam logic [7:0] RespNeedsParam = 8'hA0;
   localparam logic [7:0] CodeLimitReset = 8'd175;
   localparam logic [7:0] AwaitedReset   = 8'd0;

   localparam logic KIND_CMD = 1'b0;
   localparam logic KIND_DEV = 1'b1;

   localparam logic CSR_AWAITED_CODE = 1'b0;
   localparam logic CSR_CODE_LIMIT   = 1'b1;

   typedef enum logic [2:0] {
      ST_OK, ST_BAD_CODE, ST_TOO_LONG, ST_CHECKSUM, ST_COLUMN, ST_ROW
   } status_type;

   typedef enum logic [2:0] {
      PS_IDLE, PS_SCAN, PS_READ, PS_GOT, PS_RESULT, PS_FINISH
   } pstate_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       chunk_end;
   } item_type;

   typedef struct packed {
      logic [7:0] awaited_code;
      logic [7:0] code_limit;
   } cfg_type;

   typedef struct packed {
      logic        frame_kind;
      status_type  status;
      logic [7:0]  code_byte;
      logic [23:0] device_id;
      logic [15:0] device_data;
      logic [7:0]  param_len;
      logic [7:0]  first_param;
      logic        response_matched;
      logic        stop_request;
      logic        last;
   } result_type;

   function automatic logic parity8(input logic [7:0] v);
      return ^v;
   endfunction

endpackage

// ===== rtl/stkfp_req_if.sv =====
`timescale 1ns / 1ps
interface stkfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       chunk_end;

   modport source (output valid, rx_byte, chunk_end, input ready);
   modport sink (input valid, rx_byte, chunk_end, output ready);
endinterface

// ===== rtl/stkfp_rsp_if.sv =====
`timescale 1ns / 1ps
interface stkfp_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame_kind;
   logic [2:0]  status;
   logic [7:0]  code_byte;
   logic [23:0] device_id;
   logic [15:0] device_data;
   logic [7:0]  param_len;
   logic [7:0]  first_param;
   logic        response_matched;
   logic        stop_request;
   logic        last;

   modport source (output valid, frame_kind, status, code_byte, device_id, device_data,
                   param_len, first_param, response_matched, stop_request, last,
                   input ready);
   modport sink (input valid, frame_kind, status, code_byte, device_id, device_data,
                 param_len, first_param, response_matched, stop_request, last,
                 output ready);
endinterface

// ===== rtl/serial_two_kind_frame_parser.sv =====
`timescale 1ns / 1ps
// Serial frame parser for command frames (FF FF FF, code, length, parameters, checksum)
// and 7-byte device frames. Bytes pass through a four-beat input queue into a 64-byte
// window; a byte is taken only while the parser is idle, and the parser then reads the
// window one byte at a time through its single memory read port. Each frame attempt
// restarts in SCAN, reads each byte through READ and GOT, and issues its result in
// RESULT. A frame that is not yet complete costs a restart and byte reads until the
// shortfall shows, and then FINISH closes the byte's work. After an error the window
// drops one byte and is read again from its new start. Each result beat is held back
// until the next one, or the end of the byte's work, is known, so that last is exact;
// the parser stalls while both the held beat and the output register are occupied.
module serial_two_kind_frame_parser (
   input logic          clock,
   input logic          reset,
   stkfp_req_if.sink    req,
   stkfp_rsp_if.source  rsp,
   input logic          csr_wr_en,
   input logic          csr_index,
   input logic [7:0]    csr_wdata
);
   import stkfp_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   item_type   push_item, pop_item;
   logic       pop_valid, pop_ready;
   result_type result;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_AWAITED_CODE: cfg_in.awaited_code = csr_wdata;
            CSR_CODE_LIMIT:   cfg_in.code_limit   = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.awaited_code <= AwaitedReset;
         cfg_ff.code_limit   <= CodeLimitReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign push_item.rx_byte   = req.rx_byte;
   assign push_item.chunk_end = req.chunk_end;

   stkfp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req.valid),
      .push_ready (req.ready),
      .push_data  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_item)
   );

   stkfp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (pop_valid),
      .item_ready (pop_ready),
      .item       (pop_item),
      .out_valid  (rsp.valid),
      .out_ready  (rsp.ready),
      .out_data   (result)
   );

   assign rsp.frame_kind       = result.frame_kind;
   assign rsp.status           = result.status;
   assign rsp.code_byte        = result.code_byte;
   assign rsp.device_id        = result.device_id;
   assign rsp.device_data      = result.device_data;
   assign rsp.param_len        = result.param_len;
   assign rsp.first_param      = result.first_param;
   assign rsp.response_matched = result.response_matched;
   assign rsp.stop_request     = result.stop_request;
   assign rsp.last             = result.last;
endmodule

// ===== rtl/stkfp_fifo.sv =====
`timescale 1ns / 1ps
module stkfp_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  stkfp_pkg::item_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output stkfp_pkg::item_type pop_data
);
   import stkfp_pkg::*;

   item_type               slots_ff [FifoDepth];
   logic [FifoAddrW-1:0]   head_ff, head_in, tail_ff, tail_in;
   logic [FifoAddrW:0]     fill_ff, fill_in;
   logic                   do_push, do_pop;

   assign push_ready = (fill_ff != (FifoAddrW + 1)'(FifoDepth));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = slots_ff[head_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      head_in = do_pop ? head_ff + 1'b1 : head_ff;
      tail_in = do_push ? tail_ff + 1'b1 : tail_ff;
      fill_in = fill_ff + (FifoAddrW + 1)'(do_push) - (FifoAddrW + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[tail_ff] <= push_data;
      end
   end
endmodule

// ===== rtl/stkfp_parser.sv =====
`timescale 1ns / 1ps
`include "serial_two_kind_frame_parser_defines.svh"
module stkfp_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  stkfp_pkg::cfg_type    cfg,
   input  logic                  item_valid,
   output logic                  item_ready,
   input  stkfp_pkg::item_type   item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output stkfp_pkg::result_type out_data
);
   import stkfp_pkg::*;

   logic [7:0]         mem [BufDepth];
   logic [7:0]         rd_data_ff;
   logic [AddrW-1:0]   rd_addr, wr_addr;
   logic               wr_en;

   pstate_type         state_ff, state_in;
   logic [CountW-1:0]  count_ff, count_in;
   logic [AddrW-1:0]   start_ff, start_in;
   logic [AddrW-1:0]   k_ff, k_in;
   logic [ErrRunW-1:0] errrun_ff, errrun_in;
   logic [7:0]         bytes_ff [5];
   logic [7:0]         bytes_in [5];
   logic [4:0]         par_ff, par_in;
   logic [7:0]         xor_ff, xor_in, sum_ff, sum_in;
   logic [7:0]         code_ff, code_in, len_ff, len_in, fparam_ff, fparam_in;
   logic               col_ok_ff, col_ok_in, cmd_ff, cmd_in, chunk_ff, chunk_in;
   result_type         new_ff, new_in, held_ff, held_in, out_ff, out_in;
   logic [CountW-1:0]  consume_ff, consume_in;
   logic               held_valid_ff, held_valid_in, out_valid_ff, out_valid_in;

   // Decisions taken while a window byte is examined.
   logic               got_result, got_finish;
   logic               slot_free, proceed;
   logic               is_cmd;
   logic [NeedW-1:0]   need;
   logic [7:0]         d;
   logic [ErrRunW-1:0] err_next;
   status_type         st;

   assign d         = rd_data_ff;
   assign need      = NeedW'(6) + NeedW'(len_ff);
   assign slot_free = !out_valid_ff || out_ready;
   assign proceed   = !held_valid_ff || slot_free;
   assign rd_addr   = start_ff + k_ff;
   assign item_ready = (state_ff == PS_IDLE);
   assign wr_en     = item_valid && item_ready;
   assign wr_addr   = (count_ff == CountW'(BufDepth)) ? start_ff
                                                      : start_ff + count_ff[AddrW-1:0];
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;
   assign is_cmd    = (bytes_ff[0] == SyncByte) && (bytes_ff[1] == SyncByte) &&
                      (d == SyncByte);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= item.rx_byte;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Classification of the byte just read.
   always_comb begin
      got_result = 1'b0;
      got_finish = 1'b0;
      st         = ST_OK;
      if (k_ff == AddrW'(2)) begin
         if (is_cmd && count_ff < CountW'(6)) begin
            got_finish = 1'b1;
         end else if (!is_cmd && count_ff < CountW'(7)) begin
            got_finish = 1'b1;
         end
      end else if (cmd_ff && k_ff >= AddrW'(5)) begin
         if (k_ff == AddrW'(5) && code_ff >= cfg.code_limit) begin
            got_result = 1'b1;
            st         = ST_BAD_CODE;
         end else if (k_ff == AddrW'(5) && need > NeedW'(BufDepth)) begin
            got_result = 1'b1;
            st         = ST_TOO_LONG;
         end else if (k_ff == AddrW'(5) && NeedW'(count_ff) < need) begin
            got_finish = 1'b1;
         end else if (NeedW'(k_ff) == need - NeedW'(1)) begin
            got_result = 1'b1;
            st         = (sum_ff == d) ? ST_OK : ST_CHECKSUM;
         end
      end else if (!cmd_ff && k_ff == AddrW'(6)) begin
         got_result = 1'b1;
         if (!col_ok_ff) begin
            st = ST_COLUMN;
         end else if ((par_ff[0] ^ d[7]) != 1'b1 || (par_ff[1] ^ d[6]) != 1'b1 ||
                      (par_ff[2] ^ d[5]) != 1'b1 || (par_ff[3] ^ d[4]) != 1'b1 ||
                      (par_ff[4] ^ d[3]) != 1'b1) begin
            st = ST_ROW;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         PS_IDLE: begin
            if (wr_en) begin
               state_in = PS_SCAN;
            end
         end
         PS_SCAN: begin
            state_in = (count_ff < CountW'(3)) ? PS_FINISH : PS_READ;
         end
         PS_READ: begin
            state_in = PS_GOT;
         end
         PS_GOT: begin
            if (got_finish) begin
               state_in = PS_FINISH;
            end else if (got_result) begin
               state_in = PS_RESULT;
            end else begin
               state_in = PS_READ;
            end
         end
         PS_RESULT: begin
            if (proceed) begin
               state_in = PS_SCAN;
            end
         end
         PS_FINISH: begin
            if (proceed) begin
               state_in = PS_IDLE;
            end
         end
         default: begin
            state_in = PS_IDLE;
         end
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      count_in      = count_ff;
      start_in      = start_ff;
      k_in          = k_ff;
      errrun_in     = errrun_ff;
      bytes_in      = bytes_ff;
      par_in        = par_ff;
      xor_in        = xor_ff;
      sum_in        = sum_ff;
      code_in       = code_ff;
      len_in        = len_ff;
      fparam_in     = fparam_ff;
      col_ok_in     = col_ok_ff;
      cmd_in        = cmd_ff;
      chunk_in      = chunk_ff;
      new_in        = new_ff;
      consume_in    = consume_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && !out_ready;
      err_next      = (errrun_ff == '1) ? errrun_ff : errrun_ff + 1'b1;
      if (state_ff == PS_GOT && k_ff == AddrW'(2)) begin
         cmd_in = is_cmd;
      end
      case (state_ff)
         PS_IDLE: begin
            if (wr_en) begin
               chunk_in = item.chunk_end;
               if (count_ff == CountW'(BufDepth)) begin
                  start_in = start_ff + 1'b1;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         PS_SCAN: begin
            k_in   = '0;
            xor_in = '0;
            sum_in = '0;
         end
         PS_GOT: begin
            if (k_ff < AddrW'(5)) begin
               bytes_in[k_ff[2:0]] = d;
               par_in[k_ff[2:0]]   = parity8(d);
               xor_in              = xor_ff ^ d;
            end
            if (k_ff == AddrW'(3)) begin
               code_in = d;
            end
            if (k_ff == AddrW'(4)) begin
               len_in = d;
            end
            if (k_ff == AddrW'(5)) begin
               col_ok_in = (~xor_ff == d);
               fparam_in = (len_ff != '0) ? d : 8'd0;
            end
            if (k_ff >= AddrW'(3)) begin
               sum_in = sum_ff + d;
            end
            if (!got_finish && !got_result) begin
               k_in = k_ff + 1'b1;
            end
            new_in.status           = st;
            new_in.last             = 1'b0;
            new_in.stop_request     = 1'b0;
            new_in.response_matched = 1'b0;
            if (cmd_ff) begin
               new_in.frame_kind  = KIND_CMD;
               new_in.code_byte   = code_ff;
               new_in.device_id   = '0;
               new_in.device_data = '0;
               new_in.param_len   = len_ff;
               new_in.first_param = (k_ff == AddrW'(5)) ? fparam_in : fparam_ff;
               new_in.response_matched = (st == ST_OK) && (cfg.awaited_code != '0) &&
                  (code_ff == cfg.awaited_code) &&
                  ((code_ff != RespNeedsParam) || (len_ff != '0));
               consume_in = (st == ST_OK) ? need[CountW-1:0] : CountW'(1);
            end else begin
               new_in.frame_kind  = KIND_DEV;
               new_in.code_byte   = bytes_ff[3];
               new_in.device_id   = {bytes_ff[0], bytes_ff[1], bytes_ff[2]};
               new_in.device_data = {bytes_ff[3], bytes_ff[4]};
               new_in.param_len   = '0;
               new_in.first_param = '0;
               consume_in = (st == ST_OK) ? CountW'(7) : CountW'(1);
            end
         end
         PS_RESULT: begin
            if (proceed) begin
               if (held_valid_ff) begin
                  out_in       = held_ff;
                  out_valid_in = 1'b1;
               end
               held_in       = new_ff;
               held_valid_in = 1'b1;
               if (new_ff.status == ST_OK) begin
                  errrun_in            = '0;
                  held_in.stop_request = new_ff.response_matched;
               end else begin
                  errrun_in            = err_next;
                  held_in.stop_request = (err_next >= ErrRunW'(FailLimit));
               end
               start_in = start_ff + consume_ff[AddrW-1:0];
               count_in = count_ff - consume_ff;
            end
         end
         PS_FINISH: begin
            if (proceed) begin
               if (held_valid_ff) begin
                  out_in       = held_ff;
                  out_in.last  = 1'b1;
                  out_valid_in = 1'b1;
               end
               held_valid_in = 1'b0;
               if (chunk_ff) begin
                  count_in = '0;
                  start_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= PS_IDLE;
         count_ff      <= '0;
         start_ff      <= '0;
         errrun_ff     <= '0;
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         start_ff      <= start_in;
         errrun_ff     <= errrun_in;
         held_valid_ff <= held_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff       <= k_in;
      bytes_ff   <= bytes_in;
      par_ff     <= par_in;
      xor_ff     <= xor_in;
      sum_ff     <= sum_in;
      code_ff    <= code_in;
      len_ff     <= len_in;
      fparam_ff  <= fparam_in;
      col_ok_ff  <= col_ok_in;
      cmd_ff     <= cmd_in;
      chunk_ff   <= chunk_in;
      new_ff     <= new_in;
      consume_ff <= consume_in;
      held_ff    <= held_in;
      out_ff     <= out_in;
   end

   `STKFP_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CountW'(BufDepth))
   `STKFP_ASSERT_IMP(a_match_is_good_cmd, clock, reset, out_valid_ff && out_ff.response_matched,
      out_ff.status == ST_OK && out_ff.frame_kind == KIND_CMD)
   `STKFP_ASSERT_IMP(a_stop_cause, clock, reset,
      out_valid_ff && out_ff.stop_request && !out_ff.response_matched,
      out_ff.status != ST_OK)
   `STKFP_ASSERT_NXT(a_good_clears_run, clock, reset,
      state_ff == PS_RESULT && proceed && new_ff.status == ST_OK, errrun_ff == '0)
   `STKFP_ASSERT_NXT(a_finish_drains, clock, reset, state_ff == PS_FINISH && proceed,
      !held_valid_ff)
endmodule

// ===== tb/sv/serial_two_kind_frame_parser_test.sv =====
`timescale 1ns / 1ps
module serial_two_kind_frame_parser_test;
   import stkfp_pkg::*;

   localparam int WindowDepth = 64;
   localparam int ResultCap   = 64;
   localparam int SettleWait  = 300;
   localparam int StallLimit  = 6000;
   localparam int PhaseBytes  = 48;

   typedef struct {
      logic [7:0] rx_byte;
      logic       chunk_end;
   } beat_type;

   class frame_scoreboard;
      logic [7:0]  window[WindowDepth];
      int unsigned fill;
      int unsigned head;
      int unsigned error_run;
      logic [7:0]  awaited_code;
      logic [7:0]  code_limit;
      result_type  awaited_results[$];
      int unsigned mismatches;
      int unsigned results_seen;
      int unsigned matches_seen;
      int unsigned status_seen[6];

      function new();
         fill = 0;
         head = 0;
         error_run = 0;
         awaited_code = AwaitedReset;
         code_limit = CodeLimitReset;
         mismatches = 0;
         results_seen = 0;
         matches_seen = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function logic [7:0] peek(int unsigned k);
         return window[(head + k) % WindowDepth];
      endfunction

      function void discard(int unsigned n);
         if (n > fill) n = fill;
         head = (head + n) % WindowDepth;
         fill -= n;
      endfunction

      function void note_input(logic [7:0] b, logic ce);
         result_type batch[$];
         result_type r;
         logic [2:0] st;
         logic       matched;
         int unsigned code, len, need, sum, consume;
         logic [7:0] x;
         logic [7:0] row;
         if (fill >= WindowDepth) discard(1);
         window[(head + fill) % WindowDepth] = b;
         fill++;
         while (batch.size() < ResultCap && fill >= 3) begin
            r = '0;
            st = ST_OK;
            matched = 1'b0;
            consume = 1;
            if (peek(0) == SyncByte && peek(1) == SyncByte && peek(2) == SyncByte) begin
               if (fill < 6) break;
               code = peek(3);
               len = peek(4);
               need = 6 + len;
               if (code >= code_limit) begin
                  st = ST_BAD_CODE;
               end else if (need > WindowDepth) begin
                  st = ST_TOO_LONG;
               end else begin
                  if (fill < need) break;
                  sum = 0;
                  for (int i = 3; i + 1 < need; i++) sum += peek(i);
                  if (sum[7:0] != peek(need - 1)) begin
                     st = ST_CHECKSUM;
                  end else begin
                     consume = need;
                     matched = awaited_code != 0 && code == awaited_code &&
                               (code != RespNeedsParam || len > 0);
                  end
               end
               r.frame_kind = KIND_CMD;
               r.code_byte = code[7:0];
               r.param_len = len[7:0];
               r.first_param = len > 0 ? peek(5) : 8'd0;
            end else begin
               if (fill < 7) break;
               x = '0;
               for (int i = 0; i < 5; i++) x ^= peek(i);
               row = peek(6);
               if (~x != peek(5)) begin
                  st = ST_COLUMN;
               end else begin
                  for (int i = 0; i < 5; i++) begin
                     if ((^peek(i) ^ row[7 - i]) != 1'b1) begin
                        st = ST_ROW;
                        break;
                     end
                  end
                  if (st == ST_OK) consume = 7;
               end
               r.frame_kind = KIND_DEV;
               r.code_byte = peek(3);
               r.device_id = {peek(0), peek(1), peek(2)};
               r.device_data = {peek(3), peek(4)};
            end
            if (st != ST_OK) begin
               if (error_run < 15) error_run++;
               r.stop_request = error_run >= FailLimit;
               consume = 1;
            end else begin
               error_run = 0;
               r.stop_request = matched;
            end
            r.status = status_type'(st);
            r.response_matched = matched;
            discard(consume);
            batch.push_back(r);
         end
         if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
         foreach (batch[i]) awaited_results.push_back(batch[i]);
         if (ce) begin
            fill = 0;
            head = 0;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         string bad;
         if (awaited_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat: %p", got);
            return;
         end
         want = awaited_results.pop_front();
         bad = "";
         if (got.frame_kind !== want.frame_kind) bad = {bad, " frame_kind"};
         if (got.status !== want.status) bad = {bad, " status"};
         if (got.code_byte !== want.code_byte) bad = {bad, " code_byte"};
         if (got.device_id !== want.device_id) bad = {bad, " device_id"};
         if (got.device_data !== want.device_data) bad = {bad, " device_data"};
         if (got.param_len !== want.param_len) bad = {bad, " param_len"};
         if (got.first_param !== want.first_param) bad = {bad, " first_param"};
         if (got.response_matched !== want.response_matched) bad = {bad, " response_matched"};
         if (got.stop_request !== want.stop_request) bad = {bad, " stop_request"};
         if (got.last !== want.last) bad = {bad, " last"};
         results_seen++;
         if (want.response_matched) matches_seen++;
         status_seen[want.status]++;
         if (bad != "") begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result mismatch in%s", bad);
               $display("   expected %p", want);
               $display("   actual   %p", got);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic       csr_wr_en;
   logic       csr_index;
   logic [7:0] csr_wdata;

   stkfp_req_if req_ch();
   stkfp_rsp_if rsp_ch();

   serial_two_kind_frame_parser u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch.sink),
      .rsp       (rsp_ch.source),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   frame_scoreboard sb = new();
   beat_type byte_queue[$];
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   logic hold_off_go = 1'b0;
   logic hold_off_done;
   int unsigned hold_off_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned bytes_sent = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // The receiver either honours a requested long hold-off, once, or stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_off_left <= 0;
         hold_off_done <= 1'b0;
      end else if (hold_off_go && !hold_off_done) begin
         hold_off_left <= 400;
         hold_off_done <= 1'b1;
         rsp_ch.ready <= 1'b0;
      end else if (hold_off_left > 0) begin
         hold_off_left <= hold_off_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= $urandom_range(99) >= recv_stall_pct;
      end
   end

   always @(posedge clock) begin
      result_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) sb.note_input(req_ch.rx_byte, req_ch.chunk_end);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.frame_kind = rsp_ch.frame_kind;
            got.status = status_type'(rsp_ch.status);
            got.code_byte = rsp_ch.code_byte;
            got.device_id = rsp_ch.device_id;
            got.device_data = rsp_ch.device_data;
            got.param_len = rsp_ch.param_len;
            got.first_param = rsp_ch.first_param;
            got.response_matched = rsp_ch.response_matched;
            got.stop_request = rsp_ch.stop_request;
            got.last = rsp_ch.last;
            sb.check_result(got);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("watchdog expired with %0d results outstanding",
                  sb.awaited_results.size());
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_config(logic [7:0] awaited, logic [7:0] limit);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_AWAITED_CODE;
      csr_wdata <= awaited;
      @(posedge clock);
      csr_index <= CSR_CODE_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.awaited_code = awaited;
      sb.code_limit = limit;
   endtask

   task automatic drain_and_settle();
      while (sb.awaited_results.size() != 0) @(posedge clock);
      repeat (SettleWait) @(posedge clock);
   endtask

   task automatic send_queue();
      beat_type bt;
      while (byte_queue.size() != 0) begin
         bt = byte_queue.pop_front();
         while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
         req_ch.valid <= 1'b1;
         req_ch.rx_byte <= bt.rx_byte;
         req_ch.chunk_end <= bt.chunk_end;
         @(posedge clock);
         while (!req_ch.ready) @(posedge clock);
         bytes_sent++;
      end
      req_ch.valid <= 1'b0;
   endtask

   function automatic void add_byte(logic [7:0] b, logic ce = 1'b0);
      beat_type bt;
      bt.rx_byte = b;
      bt.chunk_end = ce;
      byte_queue.push_back(bt);
   endfunction

   // flaw: 0 good, 1 column check broken, 2 one row-parity bit flipped.
   function automatic void add_device(int flaw);
      logic [7:0] f[7];
      logic [7:0] x;
      for (int i = 0; i < 5; i++) f[i] = 8'($urandom_range(255));
      if (f[0] == SyncByte) f[0] = 8'h7F;
      x = f[0] ^ f[1] ^ f[2] ^ f[3] ^ f[4];
      f[5] = ~x;
      f[6] = 8'($urandom_range(255));
      for (int i = 0; i < 5; i++) f[6][7 - i] = ~^f[i];
      if (flaw == 1) f[5][$urandom_range(7)] ^= 1'b1;
      if (flaw == 2) f[6][7 - $urandom_range(4)] ^= 1'b1;
      foreach (f[i]) add_byte(f[i]);
   endfunction

   function automatic void add_command(logic [7:0] code, int len, logic bad_sum,
                                       logic ce = 1'b0);
      logic [7:0] sum;
      logic [7:0] p;
      add_byte(SyncByte);
      add_byte(SyncByte);
      add_byte(SyncByte);
      add_byte(code);
      add_byte(len[7:0]);
      sum = code + len[7:0];
      // An over-long frame is rejected from its header alone.
      if (len > WindowDepth - 6) return;
      for (int i = 0; i < len; i++) begin
         p = 8'($urandom_range(255));
         sum += p;
         add_byte(p);
      end
      add_byte(bad_sum ? sum ^ 8'h01 : sum, ce);
   endfunction

   function automatic logic [7:0] pick_code();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 20) return sb.awaited_code;
      if (roll < 35) return RespNeedsParam;
      if (roll < 45 || sb.code_limit == 0) return 8'($urandom_range(255));
      return 8'($urandom_range(sb.code_limit - 1));
   endfunction

   function automatic void fill_random_phase();
      int unsigned roll;
      while (byte_queue.size() < PhaseBytes) begin
         roll = $urandom_range(99);
         if (roll < 35) add_device(0);
         else if (roll < 60) add_command(pick_code(), $urandom_range(3), 1'b0);
         else if (roll < 63) add_command(pick_code(), $urandom_range(58), 1'b0);
         else if (roll < 68) add_command(pick_code(), $urandom_range(59, 255), 1'b0);
         else if (roll < 78) add_device($urandom_range(1, 2));
         else if (roll < 84) add_command(pick_code(), $urandom_range(4), 1'b1);
         else if (roll < 92) add_byte(8'($urandom_range(255)));
         else add_byte(8'($urandom_range(255)), 1'b1);
         // Occasionally cut a chunk in the middle of whatever is pending.
         if ($urandom_range(99) < 4) byte_queue[byte_queue.size() - 1].chunk_end = 1'b1;
      end
   endfunction

   initial begin
      logic [7:0]  phase_awaited[4];
      logic [7:0]  phase_limit[4];
      int unsigned phase_idle[4];
      int unsigned phase_stall[4];
      phase_awaited = '{8'h10, RespNeedsParam, 8'hFE, 8'h00};
      phase_limit = '{8'hFF, 8'hB0, 8'h00, 8'h01};
      phase_idle = '{0, 57, 0, 17};
      phase_stall = '{0, 0, 57, 17};
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_AWAITED_CODE;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.rx_byte <= '0;
      req_ch.chunk_end <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset settings, then with 0xA0 awaited.
      add_device(0);
      add_device(2);
      add_command(8'd175, 0, 1'b0);
      add_command(8'h05, 255, 1'b0);
      add_command(8'h00, 0, 1'b1, 1'b1);
      send_queue();
      drain_and_settle();
      write_config(RespNeedsParam, 8'hFF);
      add_command(RespNeedsParam, 0, 1'b0);
      add_command(RespNeedsParam, 1, 1'b0);
      add_device(1);
      add_command(8'hFE, 2, 1'b0);
      add_byte(8'hFF);
      add_byte(8'hFF, 1'b1);
      send_queue();
      drain_and_settle();

      for (int p = 0; p < 4; p++) begin
         write_config(phase_awaited[p], phase_limit[p]);
         send_idle_pct = phase_idle[p];
         recv_stall_pct = phase_stall[p];
         if (p == 1) hold_off_go = 1'b1;
         fill_random_phase();
         send_queue();
         hold_off_go = 1'b0;
         drain_and_settle();
      end

      $display("sent %0d bytes over six settings; %0d results checked, %0d matches",
               bytes_sent, sb.results_seen, sb.matches_seen);
      $display("status counts ok/code/long/sum/column/row: %0d %0d %0d %0d %0d %0d",
               sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
               sb.status_seen[3], sb.status_seen[4], sb.status_seen[5]);
      if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("status: fail");
      end
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/stkfp_pkg.sv
rtl/stkfp_req_if.sv
rtl/stkfp_rsp_if.sv
rtl/stkfp_fifo.sv
rtl/stkfp_parser.sv
rtl/serial_two_kind_frame_parser.sv
tb/sv/serial_two_kind_frame_parser_test.sv
